@@ src/quadratic_root_solver_unit_macros.svh @@
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define QRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrs check failed");
// next-cycle implication
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrs check failed");
`else
`define QRS_ASSERT_NOW(lbl, ante, cons)
`define QRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/qrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

  localparam int COEF_BITS_DEF = 15;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ROOT_BITS     = 32;
  localparam int STATUS_BITS   = 2;
  localparam int ROOT_MAX      = 2147483647;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_NONE  = 2'd0,
    ST_ONE   = 2'd1,
    ST_TWO   = 2'd2,
    ST_DEGEN = 2'd3
  } root_status_t;

endpackage
`default_nettype wire

@@ src/qrs_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt #(
  parameter int DW = 32,
  parameter int IT = 32,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_d,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [IT-1:0]      out_root,
  output logic               out_inexact,
  output logic [SW-1:0]      out_side
);
  // one result bit per stage, restoring digit-by-digit root
  localparam int RW = IT + 3;

  logic [IT-1:0] v_r;
  logic [DW-1:0] d_r    [IT];
  logic [IT-1:0] q_r    [IT];
  logic [RW-1:0] rem_r  [IT];
  logic [SW-1:0] side_r [IT];

  for (genvar i = 0; i < IT; i++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] d_in;
    logic [IT-1:0] q_in;
    logic [RW-1:0] rem_in;
    logic [SW-1:0] side_in;
    logic [RW-1:0] rem_t;
    logic [RW-1:0] trial;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    logic [IT-1:0] q_nxt;
    logic [DW-1:0] d_nxt;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign d_in    = in_d;
      assign q_in    = '0;
      assign rem_in  = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = v_r[i-1];
      assign d_in    = d_r[i-1];
      assign q_in    = q_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      rem_t   = {rem_in[RW-3:0], d_in[DW-1:DW-2]};
      trial   = {1'b0, q_in, 2'b01};
      ge      = (rem_t >= trial);
      rem_nxt = ge ? (rem_t - trial) : rem_t;
      q_nxt   = {q_in[IT-2:0], ge};
      d_nxt   = {d_in[DW-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i]    <= d_nxt;
        q_r[i]    <= q_nxt;
        rem_r[i]  <= rem_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid   = v_r[IT-1];
  assign out_root    = q_r[IT-1];
  assign out_inexact = (rem_r[IT-1] != '0);
  assign out_side    = side_r[IT-1];

endmodule
`default_nettype wire

@@ src/qrs_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qrs_div #(
  parameter int NW  = 34,
  parameter int DVW = 16,
  parameter int SW  = 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [NW-1:0]  in_num,
  input  wire logic [DVW-1:0] in_den,
  input  wire logic [SW-1:0]  in_side,
  output logic                out_valid,
  output logic [NW-1:0]       out_quot,
  output logic [SW-1:0]       out_side
);
  // restoring unsigned divide, one quotient bit per stage

  logic [NW-1:0]  v_r;
  logic [NW-1:0]  num_r  [NW];
  logic [DVW-1:0] den_r  [NW];
  logic [DVW-1:0] rem_r  [NW];
  logic [SW-1:0]  side_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic           v_in;
    logic [NW-1:0]  num_in;
    logic [DVW-1:0] den_in;
    logic [DVW-1:0] rem_in;
    logic [SW-1:0]  side_in;
    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           ge;
    logic [DVW-1:0] rem_nxt;
    logic [NW-1:0]  num_nxt;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign num_in  = in_num;
      assign den_in  = in_den;
      assign rem_in  = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = v_r[i-1];
      assign num_in  = num_r[i-1];
      assign den_in  = den_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      trial   = {rem_in, num_in[NW-1]};
      diff    = trial - {1'b0, den_in};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? diff[DVW-1:0] : trial[DVW-1:0];
      num_nxt = {num_in[NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[i]  <= num_nxt;
        den_r[i]  <= den_in;
        rem_r[i]  <= rem_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quot  = num_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule
`default_nettype wire

@@ src/quadratic_root_solver_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  beat contents
// in_      in   coef_a, coef_b, coef_c (signed, COEF_BITS each)
// out_     out  root_status, root_first, root_second (Q.FRAC_BITS)
//
// one beat in per cycle while out_ is not stalled, one beat out per beat in, in order
// stages: products, discriminant, the bit-per-stage root chain, dividends,
//   the bit-per-stage divide chains, then the output register
// rst_n is synchronous; it clears every stage valid bit
// a stall on out_ freezes the whole pipe; in_tready drops the same cycle
module quadratic_root_solver_unit #(
  parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // coef_a, coef_b, coef_c, zero pad
  input  wire logic [((3*COEF_BITS+7)/8)*8-1:0] in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // root_status, root_first, root_second, zero pad
  output logic [71:0]                           out_tdata
);
  import qrs_pkg::*;

  localparam int CB    = COEF_BITS;
  localparam int PW    = 2 * CB;              // product width
  localparam int DSW   = 2 * CB + 3;          // signed discriminant
  localparam int DW    = 2 * CB + 2;          // root radicand
  localparam int IT    = CB + 1 + FRAC_BITS;  // root bits, incl fraction
  localparam int NW    = CB + FRAC_BITS + 2;  // dividend magnitude
  localparam int NSW   = NW + 1;              // signed dividend
  localparam int DVW   = CB + 1;              // divisor magnitude
  localparam int SQSW  = 3 + 3 * CB;          // lin, status, c, b, a
  localparam int VW    = (NW + FRAC_BITS + 2 > ROOT_BITS + 1) ?
                         (NW + FRAC_BITS + 2) : (ROOT_BITS + 1);
  localparam int OUT_W = 72;
  localparam int OUT_USED = STATUS_BITS + 2 * ROOT_BITS;

  localparam logic signed [VW-1:0] SMAX = VW'(ROOT_MAX);
  localparam logic signed [VW-1:0] SMIN = -SMAX - VW'(1);

  // whole pipe moves together; last stage is the output register
  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // stage 1: products
  logic                 v1_r;
  logic signed [CB-1:0] a1_r, b1_r, c1_r;
  logic signed [PW-1:0] bb1_r, ac1_r;
  logic signed [CB-1:0] a_in, b_in, c_in;

  assign a_in = $signed(in_tdata[CB-1:0]);
  assign b_in = $signed(in_tdata[2*CB-1:CB]);
  assign c_in = $signed(in_tdata[3*CB-1:2*CB]);

  // stage 2: discriminant and case select
  logic                 v2_r;
  logic signed [DSW-1:0] disc;
  root_status_t          st2;
  logic                  lin2;
  logic [DW-1:0]         sq_d_r;
  logic [SQSW-1:0]       sq_side_r;

  always_comb begin
    disc = DSW'(bb1_r) - (DSW'(ac1_r) <<< 2);
    lin2 = 1'b0;
    if (disc[DSW-1]) begin
      st2 = ST_NONE;
    end else if (a1_r == '0 && b1_r == '0) begin
      st2 = ST_DEGEN;
    end else if (disc == '0) begin
      st2 = ST_ONE;
    end else if (a1_r == '0) begin
      st2 = ST_ONE;
      lin2 = 1'b1;
    end else begin
      st2 = ST_TWO;
    end
  end

  // root of the discriminant, floor(sqrt(D) * 2^FRAC_BITS)
  logic            sq_valid;
  logic [IT-1:0]   sq_root;
  logic            sq_inexact;
  logic [SQSW-1:0] sq_side;

  qrs_sqrt #(.DW(DW), .IT(IT), .SW(SQSW)) u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (v2_r),
    .in_d        (sq_d_r),
    .in_side     (sq_side_r),
    .out_valid   (sq_valid),
    .out_root    (sq_root),
    .out_inexact (sq_inexact),
    .out_side    (sq_side)
  );

  // stage 3: dividends, divisor, result signs
  logic                  lin3;
  root_status_t          st3;
  logic signed [CB-1:0]  a3, b3, c3;
  logic signed [NSW-1:0] nb, srx, n0, n1;
  logic signed [DVW:0]   den_s;
  logic                  inex;
  logic [NW-1:0]         mag0, mag1;
  logic [DVW-1:0]        dmag;
  logic                  neg0, neg1;

  logic                  v3_r;
  logic [NW-1:0]         mag0_r, mag1_r;
  logic [DVW-1:0]        dmag_r;
  logic [2:0]            side0_r;
  logic                  neg1_r;

  always_comb begin
    lin3 = sq_side[SQSW-1];
    st3  = root_status_t'(sq_side[SQSW-2:SQSW-3]);
    c3   = $signed(sq_side[3*CB-1:2*CB]);
    b3   = $signed(sq_side[2*CB-1:CB]);
    a3   = $signed(sq_side[CB-1:0]);
    inex = sq_inexact && (st3 == ST_TWO);
    nb   = (-NSW'(b3)) <<< FRAC_BITS;
    srx  = NSW'(sq_root);
    if (st3 == ST_TWO) begin
      n0 = nb + srx;
      n1 = nb - srx - NSW'(inex);
    end else if (lin3) begin
      n0 = -NSW'(c3);
      n1 = '0;
    end else begin
      n0 = -NSW'(b3);
      n1 = '0;
    end
    den_s = lin3 ? (DVW+1)'(b3) : ((DVW+1)'(a3) <<< 1);
    dmag  = den_s[DVW] ? DVW'(-den_s) : DVW'(den_s);
    // floor of |n + e|: one less when n is negative and e is a fraction
    mag0  = n0[NSW-1] ? NW'(-n0 - NSW'(inex)) : NW'(n0);
    mag1  = n1[NSW-1] ? NW'(-n1 - NSW'(inex)) : NW'(n1);
    neg0  = n0[NSW-1] ^ den_s[DVW];
    neg1  = n1[NSW-1] ^ den_s[DVW];
  end

  // two divide lanes, plus-root and minus-root
  logic          dv0_valid, dv1_valid;
  logic [NW-1:0] q0, q1;
  logic [2:0]    dv0_side;
  logic          dv1_side;

  qrs_div #(.NW(NW), .DVW(DVW), .SW(3)) u_div_plus (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_num    (mag0_r),
    .in_den    (dmag_r),
    .in_side   (side0_r),
    .out_valid (dv0_valid),
    .out_quot  (q0),
    .out_side  (dv0_side)
  );

  qrs_div #(.NW(NW), .DVW(DVW), .SW(1)) u_div_minus (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_num    (mag1_r),
    .in_den    (dmag_r),
    .in_side   (neg1_r),
    .out_valid (dv1_valid),
    .out_quot  (q1),
    .out_side  (dv1_side)
  );

  // final stage: sign, shift of integer quotients, saturation
  function automatic logic [ROOT_BITS-1:0] sat_root(input logic [NW-1:0] q,
                                                    input logic neg,
                                                    input logic shl);
    logic signed [VW-1:0] v;
    v = VW'(q);
    if (shl) v = v <<< FRAC_BITS;
    if (neg) v = -v;
    if (v > SMAX) return {1'b0, {(ROOT_BITS-1){1'b1}}};
    if (v < SMIN) return {1'b1, {(ROOT_BITS-1){1'b0}}};
    return v[ROOT_BITS-1:0];
  endfunction

  root_status_t         stf;
  logic [ROOT_BITS-1:0] first_nxt, second_nxt;
  logic                 out_valid_r;
  root_status_t         status_r;
  logic [ROOT_BITS-1:0] first_r, second_r;

  always_comb begin
    stf        = root_status_t'(dv0_side[2:1]);
    first_nxt  = '0;
    second_nxt = '0;
    case (stf)
      ST_ONE: begin
        first_nxt = sat_root(q0, dv0_side[0], 1'b1);
      end
      ST_TWO: begin
        first_nxt  = sat_root(q0, dv0_side[0], 1'b0);
        second_nxt = sat_root(q1, dv1_side, 1'b0);
      end
      default: begin
        first_nxt  = '0;
        second_nxt = '0;
      end
    endcase
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      v3_r        <= sq_valid;
      out_valid_r <= dv0_valid && dv1_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r      <= a_in;
      b1_r      <= b_in;
      c1_r      <= c_in;
      bb1_r     <= b_in * b_in;
      ac1_r     <= a_in * c_in;
      sq_d_r    <= disc[DSW-1] ? '0 : disc[DW-1:0];
      sq_side_r <= {lin2, st2, c1_r, b1_r, a1_r};
      mag0_r    <= mag0;
      mag1_r    <= mag1;
      dmag_r    <= dmag;
      side0_r   <= {st3, neg0};
      neg1_r    <= neg1;
      status_r  <= stf;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-OUT_USED){1'b0}}, second_r, first_r, status_r};

  `include "quadratic_root_solver_unit_macros.svh"

  `QRS_ASSERT_NOW(a_second_zero, out_tvalid && status_r != ST_TWO, second_r == '0)
  `QRS_ASSERT_NOW(a_first_zero, out_tvalid && (status_r == ST_NONE || status_r == ST_DEGEN), first_r == '0)
  `QRS_ASSERT_NOW(a_lanes_align, 1'b1, dv0_valid == dv1_valid)
  `QRS_ASSERT_NEXT(a_stall_keeps, v3_r && !en, v3_r)

endmodule
`default_nettype wire

@@ tb/quadratic_root_solver_unit_tb.sv @@
`timescale 1ns / 1ps
module quadratic_root_solver_unit_tb;
  import qrs_pkg::*;

  localparam int CB = COEF_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int IN_W = ((3 * CB + 7) / 8) * 8;
  localparam int LATENCY = 2 + (CB + 1 + FB) + 1 + (CB + FB + 2) + 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_RANDOM = 930;

  typedef struct packed {
    root_status_t status;
    logic [31:0]  first;
    logic [31:0]  second;
  } roots_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [71:0] out_tdata;

  logic [IN_W-1:0] coef_queue[$];
  roots_t expected_roots[$];
  int errors;
  int idle_cycles;
  int send_wait;
  int recv_wait;
  int hold_off;
  bit stim_done;
  bit in_beat_taken;

  quadratic_root_solver_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint coef_value(logic [CB-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > longint'(ROOT_MAX)) x = ROOT_MAX;
    if (x < -longint'(ROOT_MAX) - 1) x = -longint'(ROOT_MAX) - 1;
    return x[31:0];
  endfunction

  // floor(sqrt(d) * 2^FB) by restoring digit recurrence, plus exactness
  function automatic void root_fixed(longint unsigned d, output longint unsigned r,
                                     output bit exact);
    longint unsigned rem;
    longint unsigned pair;
    longint unsigned trial;
    r = 0;
    rem = 0;
    for (int i = 0; i < 32 + FB; i++) begin
      pair = (i < 32) ? ((d >> (62 - 2 * i)) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (r << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        r = (r << 1) | 1;
      end else begin
        r = r << 1;
      end
    end
    exact = (rem == 0);
  endfunction

  // (n + e) / d toward zero, with 0 < e < 1 when not exact
  function automatic longint div_toward_zero(longint n, bit exact, longint d);
    if (d < 0) begin
      n = exact ? -n : (-n - 1);
      d = -d;
    end
    if (n >= 0) return n / d;
    if (!exact) n = n + 1;
    return -((-n) / d);
  endfunction

  function automatic roots_t solve_roots(logic [IN_W-1:0] beat);
    roots_t res;
    longint a, b, c, disc, nb;
    longint unsigned r;
    bit exact;
    a = coef_value(beat[CB-1:0]);
    b = coef_value(beat[2*CB-1:CB]);
    c = coef_value(beat[3*CB-1:2*CB]);
    disc = b * b - 4 * a * c;
    res = '{ST_NONE, 32'd0, 32'd0};
    if (disc < 0) begin
      res.status = ST_NONE;
    end else if (a == 0 && b == 0) begin
      res.status = ST_DEGEN;
    end else if (disc == 0) begin
      res.status = ST_ONE;
      res.first = clamp32(((-b) / (2 * a)) * (longint'(1) << FB));
    end else if (a == 0) begin
      res.status = ST_ONE;
      res.first = clamp32(((-c) / b) * (longint'(1) << FB));
    end else begin
      root_fixed(longint'(disc), r, exact);
      nb = -b * (longint'(1) << FB);
      res.status = ST_TWO;
      res.first = clamp32(div_toward_zero(nb + longint'(r), exact, 2 * a));
      res.second = clamp32(div_toward_zero(exact ? nb - longint'(r) : nb - longint'(r) - 1,
                                           exact, 2 * a));
    end
    return res;
  endfunction

  function automatic logic [IN_W-1:0] pack_coefs(int a, int b, int c);
    logic [IN_W-1:0] beat;
    beat = '0;
    beat[CB-1:0] = a[CB-1:0];
    beat[2*CB-1:CB] = b[CB-1:0];
    beat[3*CB-1:2*CB] = c[CB-1:0];
    return beat;
  endfunction

  // appends one coefficient set to the pending beats
  task automatic add_coefs(int a, int b, int c);
    coef_queue = {coef_queue, pack_coefs(a, b, c)};
  endtask

  function automatic int rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16383 : -16384;
      1: return int'($urandom_range(0, 20)) - 10;
      2: return 0;
      default: return int'($urandom_range(0, 32767)) - 16384;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // stimulus: directed corners then random, biased toward real roots
  initial begin
    int a, b, c, k;
    add_coefs(0, 0, 0);
    add_coefs(0, 0, -16384);
    add_coefs(0, 0, 16383);
    add_coefs(1, 0, 1);
    add_coefs(16383, 0, 16383);
    add_coefs(1, 2, 1);
    add_coefs(-3, 6, -3);
    add_coefs(1, -16384, 0);
    add_coefs(0, 3, 7);
    add_coefs(0, -3, 7);
    add_coefs(0, 1, -16384);
    add_coefs(0, -1, -16384);
    add_coefs(0, -16384, 16383);
    add_coefs(1, 0, -1);
    add_coefs(1, 0, -2);
    add_coefs(1, -16384, -16384);
    add_coefs(-1, 16383, 16383);
    add_coefs(-16384, -16384, -16384);
    add_coefs(16383, 16383, -16384);
    add_coefs(-16384, 16383, 16383);
    add_coefs(2, -5, 3);
    add_coefs(-16384, 1, 0);
    for (k = 0; k < N_RANDOM; k++) begin
      a = rand_coef();
      b = rand_coef();
      c = rand_coef();
      // keep most items with real roots so division paths are exercised
      if ($urandom_range(0, 3) != 0 && (longint'(b) * b - 4 * longint'(a) * c) < 0) c = -c;
      add_coefs(a, b, c);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // driver: offers the next beat after a random gap; changes on falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_beat_taken) begin
        // hold the beat until it is taken
      end else if (coef_queue.size() == 0) begin
        in_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end else if (send_wait > 0) begin
        in_tvalid <= 1'b0;
        send_wait <= send_wait - 1;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= coef_queue.pop_front();
        // mostly back-to-back beats, with a random gap now and then
        send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
      end
    end
  end

  // receiver stall pattern, with random long hold-offs to fill the pipe
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        out_tready <= 1'b0;
        hold_off <= hold_off - 1;
      end else if (expected_roots.size() > 40 && !stim_done && idle_cycles == 0
                   && $urandom_range(0, 300) == 0) begin
        out_tready <= 1'b0;
        hold_off <= 200;
      end else if (recv_wait > 0) begin
        out_tready <= 1'b0;
        recv_wait <= recv_wait - 1;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid) recv_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 10) : 0;
      end
    end
  end

  // bench state init, then a forced long stall once early on
  initial begin
    hold_off = 0;
    send_wait = 0;
    recv_wait = 0;
    errors = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    in_beat_taken = 1'b0;
    wait (rst_n);
    repeat (30) @(posedge clk);
    hold_off = 300;
  end

  // monitor: predicts on accepted input, checks on accepted output
  always @(posedge clk) begin
    roots_t got;
    roots_t want;
    if (rst_n) begin
      in_beat_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) expected_roots = {expected_roots, solve_roots(in_tdata)};
      if (out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[33:2], out_tdata[65:34]};
        if (expected_roots.size() == 0) begin
          $display("unexpected result beat at %0t", $time);
          errors++;
        end else begin
          want = expected_roots.pop_front();
          if (got.status !== want.status)
            report_mismatch("root_status", 32'(got.status), 32'(want.status));
          if (got.first !== want.first) report_mismatch("root_first", got.first, want.first);
          if (got.second !== want.second)
            report_mismatch("root_second", got.second, want.second);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // end of run and watchdog
  initial begin
    wait (rst_n);
    fork
      begin
        wait (stim_done && !in_tvalid && expected_roots.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog timeout at %0t", $time);
        errors++;
      end
    join_any
    if (errors == 0) begin
      $display("quadratic_root_solver_unit test passed");
    end else begin
      $display("quadratic_root_solver_unit test failed");
    end
    $finish;
  end

endmodule
